// File: src/pdb_pkg.sv
// ----------------------------------------------------------------------------
// pdb_pkg: shared types and constants of the paletted pixel dim blend
// Item kinds, register map, queue sizing and the channel product helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pdb_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned TIDX_W   = 15;
   localparam int unsigned VALUE_W  = 24;
   localparam int unsigned PIXEL_W  = 8;
   localparam int unsigned WEIGHT_W = 7;
   localparam int unsigned COLOR_W  = 8;
   localparam int unsigned PROD_W   = 14;
   localparam int unsigned CHAN_W   = 10;
   localparam int unsigned PAL_DEPTH = 256;
   localparam int unsigned INV_DEPTH = 32768;
   localparam int unsigned PAL_IDX_W = $clog2(PAL_DEPTH);

   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 7'd64;

   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned CSR_ADDR_W  = 4;

   // Action codes on req_tuser
   localparam logic [1:0] ACT_PAL_LOAD = 2'd0;
   localparam logic [1:0] ACT_INV_LOAD = 2'd1;
   localparam logic [1:0] ACT_BLEND    = 2'd2;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_WEIGHT    = 2'd0;
   localparam logic [1:0] REG_DIM_RED   = 2'd1;
   localparam logic [1:0] REG_DIM_GREEN = 2'd2;
   localparam logic [1:0] REG_DIM_BLUE  = 2'd3;

   typedef enum logic [1:0] {
      KIND_PAL_LOAD,
      KIND_INV_LOAD,
      KIND_BLEND
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [TIDX_W-1:0]      tidx;
      logic [VALUE_W-1:0]     value;
      logic [PIXEL_W-1:0]     pixel;
   } item_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [COLOR_W-1:0]  dim_red;
      logic [COLOR_W-1:0]  dim_green;
      logic [COLOR_W-1:0]  dim_blue;
   } cfg_type;

   // 8-bit color times a weight of at most 64 fits in 14 bits
   function automatic logic [PROD_W-1:0] mix_product(input logic [COLOR_W-1:0] color,
                                                     input logic [WEIGHT_W-1:0] wt);
      logic [COLOR_W+WEIGHT_W-1:0] full;
      full = {{WEIGHT_W{1'b0}}, color} * {{COLOR_W{1'b0}}, wt};
      return full[PROD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/pdb_csr.sv
// ----------------------------------------------------------------------------
// pdb_csr: configuration registers
// APB-style register file for blend weight and dim color.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [pdb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready,
   output pdb_pkg::cfg_type                    cfg
);
   import pdb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WEIGHT:    cfg_in.weight    = csr_pwdata[WEIGHT_W-1:0];
            REG_DIM_RED:   cfg_in.dim_red   = csr_pwdata[COLOR_W-1:0];
            REG_DIM_GREEN: cfg_in.dim_green = csr_pwdata[COLOR_W-1:0];
            REG_DIM_BLUE:  cfg_in.dim_blue  = csr_pwdata[COLOR_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WEIGHT:    csr_prdata = {{(32-WEIGHT_W){1'b0}}, cfg_ff.weight};
         REG_DIM_RED:   csr_prdata = {{(32-COLOR_W){1'b0}}, cfg_ff.dim_red};
         REG_DIM_GREEN: csr_prdata = {{(32-COLOR_W){1'b0}}, cfg_ff.dim_green};
         REG_DIM_BLUE:  csr_prdata = {{(32-COLOR_W){1'b0}}, cfg_ff.dim_blue};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: src/pdb_front.sv
// ----------------------------------------------------------------------------
// pdb_front: item intake and queue
// Classifies incoming items, drops those without effect, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pdb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [1:0]                      req_tuser,
   output logic                                 head_valid,
   output pdb_pkg::item_type                    head,
   input  wire logic                            pop
);
   import pdb_pkg::*;

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   item_type               item;
   logic                   keep;
   logic                   push;
   logic                   do_pop;

   // Drop reserved actions and palette loads beyond the palette
   always_comb begin
      item.tidx  = req_tdata[TIDX_W-1:0];
      item.value = req_tdata[TIDX_W+VALUE_W-1:TIDX_W];
      item.pixel = req_tdata[TIDX_W+VALUE_W+PIXEL_W-1:TIDX_W+VALUE_W];
      item.kind  = KIND_BLEND;
      keep       = 1'b0;
      case (req_tuser)
         ACT_PAL_LOAD: begin
            item.kind = KIND_PAL_LOAD;
            keep      = (req_tdata[TIDX_W-1:PAL_IDX_W] == '0);
         end
         ACT_INV_LOAD: begin
            item.kind = KIND_INV_LOAD;
            keep      = 1'b1;
         end
         ACT_BLEND: begin
            item.kind = KIND_BLEND;
            keep      = 1'b1;
         end
         default: begin
            item.kind = KIND_BLEND;
            keep      = 1'b0;
         end
      endcase
   end

   assign req_tready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready && keep;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

// File: src/pdb_back.sv
// ----------------------------------------------------------------------------
// pdb_back: table loads and blend pipeline
// Palette stage, product stage, inverse lookup stage and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pdb_pkg::cfg_type       cfg,
   input  wire logic                   head_valid,
   input  wire pdb_pkg::item_type      head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [pdb_pkg::PIXEL_W-1:0] rsp_tdata
);
   import pdb_pkg::*;

   logic [VALUE_W-1:0] pal_mem [PAL_DEPTH];
   logic [PIXEL_W-1:0] inv_mem [INV_DEPTH];

   logic adv;

   // palette stage
   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic               s1_bypass_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [TIDX_W-1:0]  s1_tidx_ff;
   logic [PIXEL_W-1:0] s1_val_ff;
   logic [VALUE_W-1:0] s1_pal_ff;

   // product stage
   logic               s2_valid_ff;
   kind_type           s2_kind_ff;
   logic               s2_bypass_ff;
   logic [PIXEL_W-1:0] s2_pix_ff;
   logic [TIDX_W-1:0]  s2_tidx_ff;
   logic [PIXEL_W-1:0] s2_val_ff;
   logic [PROD_W-1:0]  s2_pr_ff, s2_pg_ff, s2_pb_ff;
   logic [PROD_W-1:0]  s2_dr_ff, s2_dg_ff, s2_db_ff;

   // lookup stage
   logic               s3_valid_ff;
   kind_type           s3_kind_ff;
   logic               s3_bypass_ff;
   logic [PIXEL_W-1:0] s3_pix_ff;
   logic [PIXEL_W-1:0] s3_inv_ff;

   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_data_ff;

   logic [WEIGHT_W-1:0] wt_sat;
   logic [WEIGHT_W-1:0] wt_inv;
   logic [CHAN_W-1:0]   ch_r, ch_g, ch_b;
   logic [TIDX_W-1:0]   inv_idx;

   assign adv = !out_valid_ff || rsp_tready;
   assign pop = adv && head_valid;

   assign wt_sat = (cfg.weight > FULL_WEIGHT) ? FULL_WEIGHT : cfg.weight;
   assign wt_inv = FULL_WEIGHT - wt_sat;

   assign ch_r = CHAN_W'(s2_pr_ff[PROD_W-1:4]) + CHAN_W'(s2_dr_ff[PROD_W-1:4]);
   assign ch_g = CHAN_W'(s2_pg_ff[PROD_W-1:4]) + CHAN_W'(s2_dg_ff[PROD_W-1:4]);
   assign ch_b = CHAN_W'(s2_pb_ff[PROD_W-1:4]) + CHAN_W'(s2_db_ff[PROD_W-1:4]);
   assign inv_idx = {ch_r[CHAN_W-1:5], ch_g[CHAN_W-1:5], ch_b[CHAN_W-1:5]};

   // Palette port: loads write, every item reads at its pixel
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head.kind == KIND_PAL_LOAD) begin
            pal_mem[head.tidx[PAL_IDX_W-1:0]] <= head.value;
         end
         s1_pal_ff <= pal_mem[head.pixel];
      end
   end

   // Inverse table port: loads write in order with lookups
   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         if (s2_kind_ff == KIND_INV_LOAD) begin
            inv_mem[s2_tidx_ff] <= s2_val_ff;
         end
         s3_inv_ff <= inv_mem[inv_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff   <= head.kind;
         s1_bypass_ff <= (cfg.weight == '0);
         s1_pix_ff    <= head.pixel;
         s1_tidx_ff   <= head.tidx;
         s1_val_ff    <= head.value[PIXEL_W-1:0];

         s2_kind_ff   <= s1_kind_ff;
         s2_bypass_ff <= s1_bypass_ff;
         s2_pix_ff    <= s1_pix_ff;
         s2_tidx_ff   <= s1_tidx_ff;
         s2_val_ff    <= s1_val_ff;
         s2_pr_ff     <= mix_product(s1_pal_ff[23:16], wt_inv);
         s2_pg_ff     <= mix_product(s1_pal_ff[15:8], wt_inv);
         s2_pb_ff     <= mix_product(s1_pal_ff[7:0], wt_inv);
         s2_dr_ff     <= mix_product(cfg.dim_red, wt_sat);
         s2_dg_ff     <= mix_product(cfg.dim_green, wt_sat);
         s2_db_ff     <= mix_product(cfg.dim_blue, wt_sat);

         s3_kind_ff   <= s2_kind_ff;
         s3_bypass_ff <= s2_bypass_ff;
         s3_pix_ff    <= s2_pix_ff;

         out_data_ff  <= s3_bypass_ff ? s3_pix_ff : s3_inv_ff;
      end
   end

   assign out_valid_in = adv ? (s3_valid_ff && (s3_kind_ff == KIND_BLEND)) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= head_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// File: src/palette_pixel_dim_blend.sv
// ----------------------------------------------------------------------------
// palette_pixel_dim_blend: paletted pixel dim blend, top level
// Path: an accepted blend item passes the queue, the palette, product and
// lookup stages and the result register before it shows on rsp_tvalid.
// Throughput: one item per cycle while the result side does not stall; each
// table takes its load write and its item read in the same cycle.
// Reset: synchronous; clears configuration, queue and valid flags; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pixel_dim_blend (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [14:0] table_index, [38:15] entry_value, [46:39] pixel, [47] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] blended_pixel
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import pdb_pkg::*;

   cfg_type  cfg;
   item_type head;
   logic     head_valid;
   logic     pop;

   pdb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   pdb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: src/pdb_checker.sv
// ----------------------------------------------------------------------------
// pdb_checker: port checks for the paletted pixel dim blend
// Watches the top level's ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable |-> csr_pready)
      else $error("register access stalled");

endmodule

bind palette_pixel_dim_blend pdb_checker u_checker (.*);

`default_nettype wire

// File: tb/blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_checker: item predictor and result checker for the pixel dim blend
// Watches the load/blend item channel, the result channel and register
// writes. Keeps its own palette, inverse table and register copies, computes
// the dimmed palette index for every accepted blend item and compares each
// accepted result with the oldest expected index.
// ----------------------------------------------------------------------------

module blend_checker
   import pdb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int unsigned      pending_results,
   output int unsigned      fail_count
);

   logic [VALUE_W-1:0]  palette_rgb [PAL_DEPTH];
   logic [PIXEL_W-1:0]  inverse_map [INV_DEPTH];
   logic [WEIGHT_W-1:0] weight;
   logic [COLOR_W-1:0]  dim_r;
   logic [COLOR_W-1:0]  dim_g;
   logic [COLOR_W-1:0]  dim_b;
   logic [PIXEL_W-1:0]  expected_pixels [$];

   function automatic logic [4:0] channel_top5(input logic [COLOR_W-1:0] pal,
                                               input logic [COLOR_W-1:0] dim,
                                               input logic [WEIGHT_W-1:0] amount);
      int unsigned p;
      int unsigned d;
      int unsigned w;
      int unsigned mix;
      p = pal;
      d = dim;
      w = amount;
      mix = ((p * (FULL_WEIGHT - w)) >> 4) + ((d * w) >> 4);
      return mix[9:5];
   endfunction

   function automatic logic [PIXEL_W-1:0] dimmed_index(input logic [PIXEL_W-1:0] pixel);
      logic [WEIGHT_W-1:0] amount;
      logic [VALUE_W-1:0]  rgb;
      if (weight == '0)
         return pixel;
      amount = (weight > FULL_WEIGHT) ? FULL_WEIGHT : weight;
      rgb = palette_rgb[pixel];
      return inverse_map[{channel_top5(rgb[23:16], dim_r, amount),
                          channel_top5(rgb[15:8], dim_g, amount),
                          channel_top5(rgb[7:0], dim_b, amount)}];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [TIDX_W-1:0]  tidx;
      logic [VALUE_W-1:0] value;
      logic [PIXEL_W-1:0] want;
      if (reset) begin
         weight = '0;
         dim_r = '0;
         dim_g = '0;
         dim_b = '0;
         expected_pixels.delete();
         fail_count = 0;
         pending_results <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_WEIGHT:    weight = csr_pwdata[WEIGHT_W-1:0];
               REG_DIM_RED:   dim_r = csr_pwdata[COLOR_W-1:0];
               REG_DIM_GREEN: dim_g = csr_pwdata[COLOR_W-1:0];
               REG_DIM_BLUE:  dim_b = csr_pwdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            tidx = req_tdata[14:0];
            value = req_tdata[38:15];
            case (req_tuser)
               ACT_PAL_LOAD: begin
                  if (tidx[14:8] == '0)
                     palette_rgb[tidx[7:0]] = value;
               end
               ACT_INV_LOAD: inverse_map[tidx] = value[7:0];
               ACT_BLEND:    expected_pixels.push_back(dimmed_index(req_tdata[46:39]));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("blended pixel %0d with no blend pending", rsp_tdata));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("blended pixel %0d, want %0d", rsp_tdata, want));
            end
         end
         pending_results <= expected_pixels.size();
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the paletted pixel dim blend
// Loads palette and inverse table entries, blends pixels under a series of
// weight and dim color settings with random idle bursts on both channels,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module tb;
   import pdb_pkg::*;

   localparam logic [1:0]  ACT_RESERVED = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned PHASE_ITEMS  = 100;
   localparam int unsigned PHASES       = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned pending_results;
   int unsigned fail_count;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b0;

   logic [VALUE_W-1:0]  pal_shadow [PAL_DEPTH];
   bit                  pal_loaded [PAL_DEPTH];
   bit                  inv_loaded [INV_DEPTH];
   logic [WEIGHT_W-1:0] weight_now = '0;
   logic [COLOR_W-1:0]  red_now = '0;
   logic [COLOR_W-1:0]  green_now = '0;
   logic [COLOR_W-1:0]  blue_now = '0;

   palette_pixel_dim_blend u_dut (.*);

   blend_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // RGB555 slot that a blend of this palette color reads
   function automatic logic [TIDX_W-1:0] inverse_slot(input logic [VALUE_W-1:0] rgb);
      int unsigned a;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      a = (weight_now > FULL_WEIGHT) ? FULL_WEIGHT : weight_now;
      r = ((rgb[23:16] * (FULL_WEIGHT - a)) >> 4) + ((red_now * a) >> 4);
      g = ((rgb[15:8] * (FULL_WEIGHT - a)) >> 4) + ((green_now * a) >> 4);
      b = ((rgb[7:0] * (FULL_WEIGHT - a)) >> 4) + ((blue_now * a) >> 4);
      return {r[9:5], g[9:5], b[9:5]};
   endfunction

   task automatic send_item(input logic [1:0] action, input logic [TIDX_W-1:0] tidx,
                            input logic [VALUE_W-1:0] value, input logic [PIXEL_W-1:0] pixel);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {1'b0, pixel, value, tidx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_palette(input logic [TIDX_W-1:0] tidx, input logic [VALUE_W-1:0] rgb);
      send_item(ACT_PAL_LOAD, tidx, rgb, 8'($urandom()));
      if (tidx[14:8] == '0) begin
         pal_shadow[tidx[7:0]] = rgb;
         pal_loaded[tidx[7:0]] = 1'b1;
      end
   endtask

   task automatic load_inverse(input logic [TIDX_W-1:0] tidx, input logic [VALUE_W-1:0] value);
      send_item(ACT_INV_LOAD, tidx, value, 8'($urandom()));
      inv_loaded[tidx] = 1'b1;
   endtask

   // load whatever the blend reads before it goes out
   task automatic blend_pixel(input logic [PIXEL_W-1:0] pixel);
      logic [TIDX_W-1:0] slot;
      if (weight_now != '0) begin
         if (!pal_loaded[pixel])
            load_palette({7'd0, pixel}, 24'($urandom()));
         slot = inverse_slot(pal_shadow[pixel]);
         if (!inv_loaded[slot])
            load_inverse(slot, 24'($urandom()));
      end
      send_item(ACT_BLEND, 15'($urandom()), 24'($urandom()), pixel);
   endtask

   task automatic random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         load_palette(15'($urandom_range(0, 255)), 24'($urandom()));
      else if (pick < 20)
         load_palette(15'($urandom_range(256, 32767)), 24'($urandom()));
      else if (pick < 27)
         load_inverse(15'($urandom()), 24'($urandom()));
      else if (pick < 30)
         send_item(ACT_RESERVED, 15'($urandom()), 24'($urandom()), 8'($urandom()));
      else
         blend_pixel(8'($urandom()));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] reg_index, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (reg_index)
         REG_WEIGHT:    weight_now = value[6:0];
         REG_DIM_RED:   red_now = value;
         REG_DIM_GREEN: green_now = value;
         REG_DIM_BLUE:  blue_now = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] weight, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
      drain();
      write_csr(REG_WEIGHT, weight);
      write_csr(REG_DIM_RED, red);
      write_csr(REG_DIM_GREEN, green);
      write_csr(REG_DIM_BLUE, blue);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // weight zero: pixels pass unchanged, nothing loaded yet
      blend_pixel(8'h00);
      blend_pixel(8'hff);
      load_palette(15'd0, 24'h000000);
      load_palette(15'd255, 24'hffffff);
      load_palette(15'd256, 24'h5a5a5a);
      load_palette(15'h7fff, 24'ha5a5a5);
      send_item(ACT_RESERVED, 15'h7fff, 24'hffffff, 8'hff);
      load_inverse(15'd0, 24'hffff00);
      load_inverse(15'h7fff, 24'h0000ff);
      set_config(8'd64, 8'hff, 8'hff, 8'hff);
      blend_pixel(8'h00);
      blend_pixel(8'hff);
      set_config(8'd64, 8'h00, 8'h00, 8'h00);
      blend_pixel(8'h00);
      blend_pixel(8'hff);
      set_config(8'd127, 8'hff, 8'h00, 8'hff);
      blend_pixel(8'h00);
      blend_pixel(8'hff);
      set_config(8'd1, 8'h00, 8'h00, 8'h00);
      blend_pixel(8'h00);
      blend_pixel(8'hff);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(8'd0, 8'($urandom()), 8'($urandom()), 8'($urandom()));
            1: set_config(8'd64, 8'h00, 8'h00, 8'h00);
            2: set_config(8'd64, 8'hff, 8'hff, 8'hff);
            3: set_config(8'd1, 8'($urandom()), 8'($urandom()), 8'($urandom()));
            4: set_config(8'd127, 8'($urandom()), 8'($urandom()), 8'($urandom()));
            5: set_config(8'($urandom_range(65, 126)), 8'($urandom()), 8'($urandom()),
                          8'($urandom()));
            6: set_config(8'($urandom_range(2, 63)), 8'($urandom()), 8'($urandom()),
                          8'($urandom()));
            default: set_config(8'($urandom_range(1, 64)), 8'($urandom()), 8'($urandom()),
                                8'($urandom()));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0)
               idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            random_item();
         end
      end

      drain();
      if (fail_count == 0 && pending_results == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
